FILE: rtl/f2h_pkg.sv
// f2h_pkg: shared types and constants for the binary32 to binary16 converter.
// No dependencies; used by f2h_convert and float32_to_float16_converter_core.
package f2h_pkg;

    typedef logic [31:0] single_t;
    typedef logic [15:0] half_t;

    localparam logic [7:0]  F32_EXP_ONES    = 8'hFF;
    localparam logic [7:0]  MIN_DENORM_BEXP = 8'd102;  // rebiased exponent of -10
    localparam logic [7:0]  MAX_DENORM_BEXP = 8'd112;  // rebiased exponent of 0
    localparam logic [7:0]  MAX_NORMAL_BEXP = 8'd142;  // rebiased exponent of 30
    localparam logic [7:0]  REBIAS          = 8'd112;  // 127 - 15
    localparam logic [7:0]  DENORM_SH_BASE  = 8'd113;  // shift = 113 - bexp
    localparam logic [24:0] HIDDEN_BIT      = 25'h0800000;
    localparam logic [4:0]  HALF_EXP_ONES   = 5'h1F;

endpackage

FILE: rtl/f2h_convert.sv
// f2h_convert: combinational binary32 to binary16 conversion, round half away.
// Depends on f2h_pkg.
module f2h_convert
(
    input  f2h_pkg::single_t single_bits,
    output f2h_pkg::half_t   half_bits
);

    logic        sign;
    logic [7:0]  bexp;
    logic [22:0] mant;
    logic [23:0] mrnd;
    logic [3:0]  sh;
    logic [24:0] md;
    logic [9:0]  nan_top;
    logic [4:0]  e_norm;
    logic [4:0]  e_bump;

    assign sign    = single_bits[31];
    assign bexp    = single_bits[30:23];
    assign mant    = single_bits[22:0];
    // add bit 12 into bit 13: round to nearest, ties away from zero
    assign mrnd    = {1'b0, mant} + {10'b0, mant[12], 13'b0};
    assign sh      = 4'(f2h_pkg::DENORM_SH_BASE - bexp);
    // hidden bit is added, so a rounding carry doubles the value
    assign md      = ({1'b0, mrnd} + f2h_pkg::HIDDEN_BIT) >> sh;
    assign nan_top = (mant[22:13] == 10'd0) ? 10'd1 : mant[22:13];
    assign e_norm  = 5'(bexp - f2h_pkg::REBIAS);
    assign e_bump  = 5'(bexp - f2h_pkg::REBIAS + 8'd1);

    always_comb
    begin
        if (bexp == f2h_pkg::F32_EXP_ONES)
        begin
            if (mant == 23'd0)
                half_bits = {sign, f2h_pkg::HALF_EXP_ONES, 10'd0};
            else
                half_bits = {sign, f2h_pkg::HALF_EXP_ONES, nan_top};
        end
        else if (bexp < f2h_pkg::MIN_DENORM_BEXP)
        begin
            half_bits = {sign, 15'd0};
        end
        else if (bexp <= f2h_pkg::MAX_DENORM_BEXP)
        begin
            // a carry into bit 10 gives the smallest normal
            half_bits = {sign, 4'd0, md[23:13]};
        end
        else if (bexp > f2h_pkg::MAX_NORMAL_BEXP)
        begin
            half_bits = {sign, f2h_pkg::HALF_EXP_ONES, 10'd0};
        end
        else if (mrnd[23])
        begin
            half_bits = {sign, e_bump, 10'd0};
        end
        else
        begin
            half_bits = {sign, e_norm, mrnd[22:13]};
        end
    end

endmodule

FILE: rtl/float32_to_float16_converter_core.sv
// Top level of the binary32 to binary16 converter: input register, conversion, result register.
// Depends on f2h_pkg and f2h_convert.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; busy is never raised, the two register stages overlap.
// Reset (rst_n low, asynchronous) clears both valid flags; data registers are not reset.
// Results cannot be held off: done pulses for one cycle with half_bits.
module float32_to_float16_converter_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  f2h_pkg::single_t single_bits,
    output logic             done,
    output f2h_pkg::half_t   half_bits
);

    logic             in_valid_reg;
    logic             in_valid_next;
    f2h_pkg::single_t in_data_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    f2h_pkg::half_t   out_data_reg;
    f2h_pkg::half_t   conv_half;
    logic             req_accept;

    // the pipeline never stalls, so a request is always taken
    assign busy       = 1'b0;
    assign req_accept = start && !busy;

    assign in_valid_next  = req_accept;
    assign out_valid_next = in_valid_reg;

    // stage 1: capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            in_data_reg <= single_bits;
    end

    // conversion between the two register stages
    f2h_convert u_convert
    (
        .single_bits (in_data_reg),
        .half_bits   (conv_half)
    );

    // stage 2: result register, shown for exactly one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            out_data_reg <= conv_half;
    end

    assign done      = out_valid_reg;
    assign half_bits = out_data_reg;

    // every accepted request produces a result through both register stages
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |-> ##2 done)
        else $error("accepted request produced no result");

    // no result without an earlier accepted request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_accept, 2))
        else $error("result without a matching request");

    // stage 1 valid always drains into the result stage
    a_stage_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done)
        else $error("stage 1 item lost");

endmodule
